// ===== rtl/gdrm_pkg.sv =====
// shared constants, codes and controller/datapath link types for the delta-r matcher
package gdrm_pkg;

    // list sizes
    localparam int MAX_OBJECTS = 64;
    localparam int MAX_REGIONS = 64;

    // field widths
    localparam int CMD_W   = 2;
    localparam int COORD_W = 13;
    localparam int IDX_W   = 6;
    localparam int DIST_W  = 27;

    // store addressing and fill counts
    localparam int OBJ_AW  = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int REG_AW  = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int OBJ_CW  = $clog2(MAX_OBJECTS + 1);
    localparam int REG_CW  = $clog2(MAX_REGIONS + 1);
    localparam int ENTRY_W = 2 * COORD_W;

    // fixed-point geometry, units of 1/1024 rad
    localparam int PI_FX     = 3217;
    localparam int TWO_PI_FX = 6434;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int AE_W      = COORD_W;
    localparam int AP_W      = $clog2(PI_FX + 1);
    localparam int SQE_W     = 2 * AE_W;
    localparam int SQP_W     = 2 * AP_W;

    // squared distances, units of 2^-20
    localparam logic [DIST_W-1:0] NO_CAND_DIST = DIST_W'(104857600);
    localparam logic [DIST_W-1:0] RADIUS_RESET = DIST_W'(1048576);

    // input command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_OBJ = 2'd0,
        CMD_LOAD_REG = 2'd1,
        CMD_RUN      = 2'd2
    } t_cmd;

    // controller to datapath
    typedef struct packed {
        logic load_obj;
        logic load_reg;
        logic issue;
        logic emit;
        logic clear;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic obj_empty;
        logic obj_last;
        logic scan_done;
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/gdrm_chan_if.sv =====
// valid/ready channel interfaces for command words and result words

interface gdrm_cmd_if import gdrm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          command;
    logic signed [COORD_W-1:0] eta;
    logic signed [COORD_W-1:0] phi;

    modport source (output valid, output command, output eta, output phi, input ready);
    modport sink   (input valid, input command, input eta, input phi, output ready);
endinterface

interface gdrm_res_if import gdrm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  object_index;
    logic [IDX_W-1:0]  region_index;
    logic              found;
    logic              matched;
    logic [DIST_W-1:0] best_dist_sq;
    logic              last;

    modport source (output valid, output object_index, output region_index, output found,
                    output matched, output best_dist_sq, output last, input ready);
    modport sink   (input valid, input object_index, input region_index, input found,
                    input matched, input best_dist_sq, input last, output ready);
endinterface

// ===== rtl/greedy_delta_r_matcher.sv =====
// greedy delta-r matcher top level
//
//   channel   direction  word                                         handshake
//   i_cmd     in         command, eta, phi                            valid/ready
//   o_res     out        object_index, region_index, found, matched,  valid/ready
//                        best_dist_sq, last
//   i_cfg_*   in         match_radius_sq                              write enable
//
// loads are taken while idle; a run command is taken and then
// blocks the command channel while the objects are walked.
// each object is scanned against every loaded region:
// the region store read port walks one region a cycle into a three-stage
// distance pipeline.
// a stall on o_res holds the walk only when the next result is due and the
// result register is still full.
// reset is synchronous: lists, claim flags and result register empty, radius 1.0.
module greedy_delta_r_matcher import gdrm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    gdrm_cmd_if.sink          i_cmd,
    gdrm_res_if.source        o_res,
    input  logic              i_cfg_we,
    input  logic [DIST_W-1:0] i_cfg_wdata
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencing
    gdrm_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_cmd.valid),
        .i_in_command (i_cmd.command),
        .o_in_ready   (i_cmd.ready),
        .i_stat       (w_stat),
        .o_cmd        (w_cmd)
    );

    // stores and distance arithmetic
    gdrm_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_eta          (i_cmd.eta),
        .i_phi          (i_cmd.phi),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_out_ready    (o_res.ready),
        .o_out_valid    (o_res.valid),
        .o_object_index (o_res.object_index),
        .o_region_index (o_res.region_index),
        .o_found        (o_res.found),
        .o_matched      (o_res.matched),
        .o_best_dist_sq (o_res.best_dist_sq),
        .o_last         (o_res.last)
    );

endmodule

// ===== rtl/gdrm_ram.sv =====
// generic simple dual-port ram with registered read
module gdrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/gdrm_datapath.sv =====
// matcher datapath: stores, distance pipeline, best tracking, claim flags, result register
module gdrm_datapath import gdrm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [COORD_W-1:0] i_eta,
    input  logic signed [COORD_W-1:0] i_phi,
    input  logic                      i_cfg_we,
    input  logic [DIST_W-1:0]         i_cfg_wdata,
    input  t_dp_cmd                   i_cmd,
    output t_dp_stat                  o_stat,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [IDX_W-1:0]          o_object_index,
    output logic [IDX_W-1:0]          o_region_index,
    output logic                      o_found,
    output logic                      o_matched,
    output logic [DIST_W-1:0]         o_best_dist_sq,
    output logic                      o_last
);

    localparam logic signed [DIFF_W-1:0] PI_D     = DIFF_W'(PI_FX);
    localparam logic signed [DIFF_W-1:0] NEG_PI_D = -DIFF_W'(PI_FX);
    localparam logic signed [DIFF_W-1:0] TWO_PI_D = DIFF_W'(TWO_PI_FX);

    // control state
    logic [OBJ_CW-1:0]      r_obj_cnt;
    logic [REG_CW-1:0]      r_reg_cnt;
    logic [OBJ_CW-1:0]      r_obj_i;
    logic [REG_CW-1:0]      r_reg_j;
    logic [MAX_REGIONS-1:0] r_claimed;
    logic [DIST_W-1:0]      r_radius;
    logic                   r_v1, r_v2, r_v3;
    logic [DIST_W-1:0]      r_best;
    logic [REG_AW-1:0]      r_best_idx;
    logic                   r_found;
    logic                   r_out_valid;

    // pipeline payload
    logic [REG_AW-1:0] r_j1, r_j2, r_j3;
    logic [AE_W-1:0]   r_ae;
    logic [AP_W-1:0]   r_ap;
    logic [SQE_W-1:0]  r_sq_e;
    logic [SQP_W-1:0]  r_sq_p;

    // result payload
    logic [IDX_W-1:0]  r_out_obj;
    logic [IDX_W-1:0]  r_out_reg;
    logic              r_out_found;
    logic              r_out_matched;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_last;

    logic                      w_obj_we, w_reg_we;
    logic [ENTRY_W-1:0]        w_obj_rd, w_reg_rd;
    logic signed [DIFF_W-1:0]  w_de, w_dp_raw, w_dp, w_ae_full, w_ap_full;
    logic [SQE_W-1:0]          w_sq_e;
    logic [SQP_W-1:0]          w_sq_p;
    logic [DIST_W-1:0]         w_dist;
    logic                      w_better;
    logic                      w_matched;
    logic                      w_obj_last;

    // object and region coordinate stores
    assign w_obj_we = i_cmd.load_obj && (r_obj_cnt != OBJ_CW'(MAX_OBJECTS));
    assign w_reg_we = i_cmd.load_reg && (r_reg_cnt != REG_CW'(MAX_REGIONS));

    gdrm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_OBJECTS)) u_obj_ram (
        .i_clk   (i_clk),
        .i_we    (w_obj_we),
        .i_waddr (r_obj_cnt[OBJ_AW-1:0]),
        .i_wdata ({i_eta, i_phi}),
        .i_raddr (r_obj_i[OBJ_AW-1:0]),
        .o_rdata (w_obj_rd)
    );

    gdrm_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_REGIONS)) u_reg_ram (
        .i_clk   (i_clk),
        .i_we    (w_reg_we),
        .i_waddr (r_reg_cnt[REG_AW-1:0]),
        .i_wdata ({i_eta, i_phi}),
        .i_raddr (r_reg_j[REG_AW-1:0]),
        .o_rdata (w_reg_rd)
    );

    // stage 1: coordinate differences, phi wrapped into [-pi, pi), magnitudes
    always_comb begin
        w_de = {w_obj_rd[ENTRY_W-1], w_obj_rd[ENTRY_W-1:COORD_W]}
             - {w_reg_rd[ENTRY_W-1], w_reg_rd[ENTRY_W-1:COORD_W]};
        w_dp_raw = {w_obj_rd[COORD_W-1], w_obj_rd[COORD_W-1:0]}
                 - {w_reg_rd[COORD_W-1], w_reg_rd[COORD_W-1:0]};
        if (w_dp_raw >= PI_D) begin
            w_dp = w_dp_raw - TWO_PI_D;
        end else if (w_dp_raw < NEG_PI_D) begin
            w_dp = w_dp_raw + TWO_PI_D;
        end else begin
            w_dp = w_dp_raw;
        end
        w_ae_full = w_de[DIFF_W-1] ? -w_de : w_de;
        w_ap_full = w_dp[DIFF_W-1] ? -w_dp : w_dp;
    end

    // stage 2: squares
    assign w_sq_e = SQE_W'(r_ae) * SQE_W'(r_ae);
    assign w_sq_p = SQP_W'(r_ap) * SQP_W'(r_ap);

    // stage 3: sum and compare against the running best, skipping claimed regions
    assign w_dist   = DIST_W'(r_sq_e) + DIST_W'(r_sq_p);
    assign w_better = r_v3 && !r_claimed[r_j3] && (w_dist < r_best);

    assign w_matched  = r_found && (r_best <= r_radius);
    assign w_obj_last = (r_obj_i + OBJ_CW'(1)) == r_obj_cnt;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_cnt   <= '0;
            r_reg_cnt   <= '0;
            r_obj_i     <= '0;
            r_reg_j     <= '0;
            r_claimed   <= '0;
            r_radius    <= RADIUS_RESET;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_best      <= NO_CAND_DIST;
            r_best_idx  <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radius <= i_cfg_wdata;
            end
            if (w_obj_we) begin
                r_obj_cnt <= r_obj_cnt + OBJ_CW'(1);
            end
            if (w_reg_we) begin
                r_reg_cnt <= r_reg_cnt + REG_CW'(1);
            end

            // region walk
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_cmd.issue) begin
                r_reg_j <= r_reg_j + REG_CW'(1);
            end

            // nearest-candidate tracking
            if (i_cmd.emit) begin
                r_best     <= NO_CAND_DIST;
                r_best_idx <= '0;
                r_found    <= 1'b0;
                r_reg_j    <= '0;
            end else if (w_better) begin
                r_best     <= w_dist;
                r_best_idx <= r_j3;
                r_found    <= 1'b1;
            end

            // object walk and claims; end of run empties both lists
            if (i_cmd.clear) begin
                r_obj_cnt <= '0;
                r_reg_cnt <= '0;
                r_obj_i   <= '0;
                r_claimed <= '0;
            end else if (i_cmd.emit) begin
                r_obj_i <= r_obj_i + OBJ_CW'(1);
                if (w_matched) begin
                    r_claimed[r_best_idx] <= 1'b1;
                end
            end

            // result register occupancy
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_j1   <= r_reg_j[REG_AW-1:0];
        r_j2   <= r_j1;
        r_j3   <= r_j2;
        r_ae   <= w_ae_full[AE_W-1:0];
        r_ap   <= w_ap_full[AP_W-1:0];
        r_sq_e <= w_sq_e;
        r_sq_p <= w_sq_p;
        if (i_cmd.emit) begin
            r_out_obj     <= IDX_W'(r_obj_i);
            r_out_reg     <= IDX_W'(r_best_idx);
            r_out_found   <= r_found;
            r_out_matched <= w_matched;
            r_out_dist    <= r_best;
            r_out_last    <= w_obj_last;
        end
    end

    // status to controller
    assign o_stat.obj_empty = (r_obj_cnt == '0);
    assign o_stat.obj_last  = w_obj_last;
    assign o_stat.scan_done = (r_reg_j == r_reg_cnt);
    assign o_stat.pipe_busy = r_v1 || r_v2 || r_v3;
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    // result word
    assign o_out_valid    = r_out_valid;
    assign o_object_index = r_out_obj;
    assign o_region_index = r_out_reg;
    assign o_found        = r_out_found;
    assign o_matched      = r_out_matched;
    assign o_best_dist_sq = r_out_dist;
    assign o_last         = r_out_last;

endmodule

// ===== rtl/gdrm_ctrl.sv =====
// matcher controller: command decode and per-object scan sequencing
module gdrm_ctrl import gdrm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic [CMD_W-1:0] i_in_command,
    output logic             o_in_ready,
    input  t_dp_stat         i_stat,
    output t_dp_cmd          o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state r_state, n_state;

    // next state and datapath commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (i_in_command)
                        CMD_LOAD_OBJ: o_cmd.load_obj = 1'b1;
                        CMD_LOAD_REG: o_cmd.load_reg = 1'b1;
                        CMD_RUN: begin
                            if (i_stat.obj_empty) begin
                                o_cmd.clear = 1'b1;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.issue = 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.obj_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== dv/tb_greedy_delta_r_matcher.sv =====
// self-checking testbench for the greedy delta-r matcher: directed and random loads and runs against a predictor
`timescale 1ns / 100ps

module tb_greedy_delta_r_matcher import gdrm_pkg::*; ();

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 33;
    localparam int SETTLE_CYCLES  = MAX_REGIONS + 16;
    localparam int WATCHDOG_LIMIT = 20000;

    // one result word as the block reports it
    typedef struct {
        logic [IDX_W-1:0]  object_index;
        logic [IDX_W-1:0]  region_index;
        logic              found;
        logic              matched;
        logic [DIST_W-1:0] best_dist_sq;
        logic              last;
    } t_match_result;

    // greedy matching predictor and queue of expected result words
    class t_match_scoreboard;
        logic signed [COORD_W-1:0] obj_eta[MAX_OBJECTS];
        logic signed [COORD_W-1:0] obj_phi[MAX_OBJECTS];
        logic signed [COORD_W-1:0] reg_eta[MAX_REGIONS];
        logic signed [COORD_W-1:0] reg_phi[MAX_REGIONS];
        bit                        claimed[MAX_REGIONS];
        int                        obj_count;
        int                        reg_count;
        logic [DIST_W-1:0]         radius_sq;
        t_match_result             expected_q[$];
        int                        errors;

        function new();
            radius_sq = RADIUS_RESET;
            obj_count = 0;
            reg_count = 0;
            errors    = 0;
            foreach (claimed[j]) claimed[j] = 1'b0;
        endfunction

        function void set_radius(logic [DIST_W-1:0] value);
            radius_sq = value;
        endfunction

        // squared eta-phi distance with the phi difference folded into [-pi, pi)
        function int pair_dist_sq(logic signed [COORD_W-1:0] e1, logic signed [COORD_W-1:0] p1,
                                  logic signed [COORD_W-1:0] e2, logic signed [COORD_W-1:0] p2);
            int de;
            int dp;
            de = int'(e1) - int'(e2);
            dp = int'(p1) - int'(p2);
            while (dp >= PI_FX) dp -= TWO_PI_FX;
            while (dp < -PI_FX) dp += TWO_PI_FX;
            return de * de + dp * dp;
        endfunction

        // greedy walk over objects in load order, then clear the lists
        function void run_matching();
            t_match_result res;
            int best;
            int best_idx;
            int d;
            bit hit;
            for (int i = 0; i < obj_count; i++) begin
                best     = int'(NO_CAND_DIST);
                best_idx = 0;
                hit      = 1'b0;
                for (int j = 0; j < reg_count; j++) begin
                    if (!claimed[j]) begin
                        d = pair_dist_sq(obj_eta[i], obj_phi[i], reg_eta[j], reg_phi[j]);
                        if (d < best) begin
                            best     = d;
                            best_idx = j;
                            hit      = 1'b1;
                        end
                    end
                end
                res.object_index = IDX_W'(i);
                res.region_index = hit ? IDX_W'(best_idx) : '0;
                res.found        = hit;
                res.matched      = hit && (DIST_W'(best) <= radius_sq);
                res.best_dist_sq = DIST_W'(best);
                res.last         = (i == obj_count - 1);
                if (res.matched) claimed[best_idx] = 1'b1;
                expected_q.insert(expected_q.size(), res);
            end
            foreach (claimed[j]) claimed[j] = 1'b0;
            obj_count = 0;
            reg_count = 0;
        endfunction

        // accepted command word
        function void note_command(logic [CMD_W-1:0] cmd, logic signed [COORD_W-1:0] eta,
                                   logic signed [COORD_W-1:0] phi);
            case (cmd)
                CMD_LOAD_OBJ: begin
                    if (obj_count < MAX_OBJECTS) begin
                        obj_eta[obj_count] = eta;
                        obj_phi[obj_count] = phi;
                        obj_count++;
                    end
                end
                CMD_LOAD_REG: begin
                    if (reg_count < MAX_REGIONS) begin
                        reg_eta[reg_count] = eta;
                        reg_phi[reg_count] = phi;
                        reg_count++;
                    end
                end
                CMD_RUN: begin
                    run_matching();
                end
                default: begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [DIST_W-1:0] exp_v,
                                    logic [DIST_W-1:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
                errors++;
            end
        endfunction

        // accepted result word against the oldest expectation
        function void check_result(t_match_result got);
            t_match_result exp_r;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: object_index %0d", got.object_index);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            compare_field("object_index", DIST_W'(exp_r.object_index),
                          DIST_W'(got.object_index));
            compare_field("region_index", DIST_W'(exp_r.region_index),
                          DIST_W'(got.region_index));
            compare_field("found", DIST_W'(exp_r.found), DIST_W'(got.found));
            compare_field("matched", DIST_W'(exp_r.matched), DIST_W'(got.matched));
            compare_field("best_dist_sq", exp_r.best_dist_sq, got.best_dist_sq);
            compare_field("last", DIST_W'(exp_r.last), DIST_W'(got.last));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [DIST_W-1:0] i_cfg_wdata;

    gdrm_cmd_if cmd_ch ();
    gdrm_res_if res_ch ();

    t_match_scoreboard sb;
    int                items_sent = 0;
    bit                no_gap_stretch = 1'b0;
    int                idle_cycles = 0;

    greedy_delta_r_matcher DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_ch),
        .o_res       (res_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // result checking at the rising edge
    always @(posedge i_clk) begin
        t_match_result got;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            got.object_index = res_ch.object_index;
            got.region_index = res_ch.region_index;
            got.found        = res_ch.found;
            got.matched      = res_ch.matched;
            got.best_dist_sq = res_ch.best_dist_sq;
            got.last         = res_ch.last;
            sb.check_result(got);
        end
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // result-side back-pressure: short and long stalls, plus stall-free stretches
    initial begin : ready_pattern
        int run_len;
        int pick;
        logic level;
        res_ch.ready <= 1'b0;
        forever begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                level   = 1'b1;
                run_len = $urandom_range(150, 30);
            end else if (pick < 70) begin
                level   = 1'b1;
                run_len = $urandom_range(6, 1);
            end else if (pick < 95) begin
                level   = 1'b0;
                run_len = $urandom_range(3, 1);
            end else begin
                level   = 1'b0;
                run_len = $urandom_range(60, 20);
            end
            repeat (run_len) begin
                @(negedge i_clk);
                res_ch.ready <= level;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gap_stretch || r < 60) return 0;
        if (r < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_eta();
        return COORD_W'(int'($urandom_range(8191)) - 4096);
    endfunction

    function automatic logic signed [COORD_W-1:0] rand_phi();
        return COORD_W'(int'($urandom_range(2 * PI_FX)) - PI_FX);
    endfunction

    // coordinate near a given one, eta clipped and phi folded back into range
    function automatic logic signed [COORD_W-1:0] near_eta(logic signed [COORD_W-1:0] e,
                                                            int spread);
        int v;
        v = int'(e) + int'($urandom_range(2 * spread)) - spread;
        if (v > 4095) v = 4095;
        if (v < -4096) v = -4096;
        return COORD_W'(v);
    endfunction

    function automatic logic signed [COORD_W-1:0] near_phi(logic signed [COORD_W-1:0] p,
                                                            int spread);
        int v;
        v = int'(p) + int'($urandom_range(2 * spread)) - spread;
        if (v > PI_FX) v -= TWO_PI_FX;
        if (v < -PI_FX) v += TWO_PI_FX;
        return COORD_W'(v);
    endfunction

    // one command word; entered and left at a falling edge
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic signed [COORD_W-1:0] eta,
                             input logic signed [COORD_W-1:0] phi);
        int gap;
        gap = pick_gap();
        if (gap != 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= cmd;
        cmd_ch.eta     <= eta;
        cmd_ch.phi     <= phi;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sb.note_command(cmd, eta, phi);
        if (cmd != CMD_UNUSED) items_sent++;
        @(negedge i_clk);
    endtask

    // hold the sender until every expected word is back, then let the block settle
    task automatic wait_drained();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_radius(input logic [DIST_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_radius(value);
        @(negedge i_clk);
    endtask

    // loads in random order, regions mostly close to the objects, then a run
    task automatic run_sequence(input int n_obj, input int n_reg);
        logic signed [COORD_W-1:0] oe[$];
        logic signed [COORD_W-1:0] op[$];
        int spread;
        int oi;
        int ri;
        int k;
        case ($urandom_range(3))
            0: spread = 0;
            1: spread = 300;
            2: spread = 1100;
            default: spread = 2500;
        endcase
        for (k = 0; k < n_obj; k++) begin
            oe.insert(oe.size(), rand_eta());
            op.insert(op.size(), rand_phi());
        end
        oi = 0;
        ri = 0;
        while (oi < n_obj || ri < n_reg) begin
            if ($urandom_range(19) == 0) send_word(CMD_UNUSED, rand_eta(), rand_phi());
            if (ri >= n_reg || (oi < n_obj && $urandom_range(1) == 0)) begin
                send_word(CMD_LOAD_OBJ, oe[oi], op[oi]);
                oi++;
            end else begin
                if (n_obj > 0 && $urandom_range(3) != 0) begin
                    k = $urandom_range(n_obj - 1);
                    send_word(CMD_LOAD_REG, near_eta(oe[k], spread), near_phi(op[k], spread));
                end else begin
                    send_word(CMD_LOAD_REG, rand_eta(), rand_phi());
                end
                ri++;
            end
        end
        send_word(CMD_RUN, rand_eta(), rand_phi());
    endtask

    function automatic logic [DIST_W-1:0] radius_for_phase(int ph);
        case (ph)
            0: return '0;
            1: return {DIST_W{1'b1}};
            2: return RADIUS_RESET;
            3: return DIST_W'($urandom_range(4 << 20));
            4: return DIST_W'($urandom);
            5: return {DIST_W{1'b1}};
            6: return DIST_W'($urandom_range(1 << 16));
            default: return '0;
        endcase
    endfunction

    // main sequence
    initial begin
        int n_obj;
        int n_reg;
        int pick;
        int target;
        sb = new();
        i_rst_n        <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_LOAD_OBJ;
        cmd_ch.eta     <= '0;
        cmd_ch.phi     <= '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed part at the default radius
        send_word(CMD_UNUSED, 13'sd1234, -13'sd2000);
        send_word(CMD_RUN, '0, '0);                        // empty run
        send_word(CMD_LOAD_OBJ, '0, '0);
        send_word(CMD_RUN, '0, '0);                        // object with no regions
        send_word(CMD_LOAD_OBJ, -13'sd4096, -13'sd3217);
        send_word(CMD_LOAD_OBJ, 13'sd4095, 13'sd3217);
        send_word(CMD_LOAD_OBJ, '0, '0);
        send_word(CMD_LOAD_REG, 13'sd4095, -13'sd3217);    // same point across the phi seam
        send_word(CMD_UNUSED, -13'sd1, -13'sd1);
        send_word(CMD_LOAD_REG, -13'sd4096, 13'sd3217);
        send_word(CMD_LOAD_REG, 13'sd10, '0);              // equal distances, lower index wins
        send_word(CMD_LOAD_REG, -13'sd10, '0);
        send_word(CMD_LOAD_REG, 13'sd10, '0);
        send_word(CMD_RUN, '0, '0);
        send_word(CMD_LOAD_OBJ, -13'sd4096, '0);           // far pair, found but not matched
        send_word(CMD_LOAD_REG, 13'sd4095, 13'sd3216);
        send_word(CMD_RUN, '0, '0);
        send_word(CMD_LOAD_OBJ, 13'sd100, 13'sd100);       // second object finds its region taken
        send_word(CMD_LOAD_OBJ, 13'sd101, 13'sd100);
        send_word(CMD_LOAD_REG, 13'sd100, 13'sd100);
        send_word(CMD_RUN, '0, '0);

        // random phases, each at its own radius
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            write_radius(radius_for_phase(ph));
            target = items_sent + PHASE_ITEMS;
            // both lists overfilled once
            if (ph == 3) run_sequence(MAX_OBJECTS + 6, MAX_REGIONS + 4);
            while (items_sent < target) begin
                no_gap_stretch = ($urandom_range(3) == 0);
                pick = $urandom_range(99);
                if (pick < 8) begin
                    n_obj = 0;
                    n_reg = $urandom_range(3);
                end else if (pick < 20) begin
                    n_obj = $urandom_range(20, 7);
                    n_reg = $urandom_range(24, 4);
                end else begin
                    n_obj = $urandom_range(6, 1);
                    n_reg = $urandom_range(8);
                end
                run_sequence(n_obj, n_reg);
                if ($urandom_range(7) == 0) wait_drained();
            end
        end

        wait_drained();
        if (sb.pending() != 0) sb.errors++;
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
